FILE: src/dht_pkg.sv
// Shared constants, codes and types of the double-hashing table.
`default_nettype none

package dht_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 11;
    localparam int MARK_W = 2;

    // Bit-serial remainder unit: one dividend bit a cycle
    localparam int                DIV_CW   = $clog2(KEY_W);
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(KEY_W - 1);

    // Operation codes
    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND  = 2'd2;

    // Result codes
    localparam logic [STAT_W-1:0] STAT_STORED     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ERASED     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ERASE_MISS = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FOUND      = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd5;

    // Slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OCC   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DEL   = 2'd2;

    // Register map (index taken from paddr[2])
    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_STEP_MOD   = 1'b1;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [CFG_W-1:0] STEP_MOD_RST   = 11'd7;

    // Sequencer states
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MODQ  = 8'b0000_0100,
        S_MODN  = 8'b0000_1000,
        S_MODS  = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } dht_state_t;

endpackage

`default_nettype wire

FILE: src/dht_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] addr,
    input  wire [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on strobe, register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/double_hash_table.sv
// Open-addressing hash table with double hashing and deletion marks.
//
//  channel  | direction | transfer contents
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | tuser: action; tdata: key, value (operation)
//  m_       | out       | tuser: status; tdata: found_value (result)
//  APB      | in/out    | 0x0 table_size, 0x4 step_modulus (read/write)
//
// Each item runs three remainders (key mod q, key mod n, step mod n) through one
// bit-serial remainder unit at one dividend bit a cycle, then probes from 1 to n
// slots, n being the effective table size. Each probe is one read of the
// single-port slot RAM, whose read data is registered, then a decision state.
// An unused action code goes straight to the finishing state with status not
// found. After reset a clearing pass marks all slots empty; no item is taken
// meanwhile. A finished result waits in the output register; the next item is
// accepted, and its result held, until the previous one is taken.
`default_nettype none

module double_hash_table #(
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Operation stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [30:0] key, [62:31] value, [63] zero
    input  wire  [1:0]  s_tuser,   // [1:0] action
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] found_value
    output logic [2:0]  m_tuser,   // [2:0] status
    // Configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int KEY_W  = dht_pkg::KEY_W;
    localparam int CFG_W  = dht_pkg::CFG_W;
    localparam int MARK_W = dht_pkg::MARK_W;
    localparam int SW     = $clog2(CAPACITY);
    localparam int NW     = $clog2(CAPACITY + 1);
    localparam int DW     = (NW > CFG_W) ? NW : CFG_W;
    localparam int PW     = MARK_W + KEY_W + PAYLOAD_BITS;

    // Configuration registers
    logic [CFG_W-1:0] tsize_reg, tsize_next;
    logic [CFG_W-1:0] qmod_reg, qmod_next;

    // Sequencer and counters
    dht_pkg::dht_state_t state_reg, state_next;
    logic [SW-1:0]             clr_reg, clr_next;
    logic [dht_pkg::DIV_CW-1:0] dcnt_reg, dcnt_next;
    logic [NW-1:0]             probe_reg, probe_next;

    // Item and working values
    logic [dht_pkg::ACT_W-1:0] act_reg, act_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]   val_reg, val_next;
    logic [KEY_W-1:0]          dvd_reg, dvd_next;
    logic [DW-1:0]             rem_reg, rem_next;
    logic [DW-1:0]             step_reg, step_next;
    logic [SW-1:0]             slot_reg, slot_next;
    logic [SW-1:0]             stride_reg, stride_next;
    logic [dht_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [31:0]               res_value_reg, res_value_next;

    // Output register
    logic                      m_valid_reg, m_valid_next;
    logic [dht_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic [31:0]               m_value_reg, m_value_next;

    // Combinational helpers
    logic [DW-1:0]           eff_n, eff_q, divisor, rem_step;
    logic [DW:0]             trial;
    logic [SW:0]             slot_sum, n_ext;
    logic [SW-1:0]           slot_adv;
    logic                    last_probe, s_xfer, cfg_wr;
    logic                    ram_we;
    logic [SW-1:0]           ram_addr;
    logic [PW-1:0]           ram_wdata, ram_rdata;
    logic [MARK_W-1:0]       rd_mark;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay, pay_in;
    logic [31:0]             rd_pay32;

    // Fit payload width to the 32-bit value field
    generate
        if (PAYLOAD_BITS <= dht_pkg::VAL_W) begin : g_pay_narrow
            assign pay_in = s_tdata[KEY_W +: PAYLOAD_BITS];
        end else begin : g_pay_wide
            assign pay_in = {{(PAYLOAD_BITS - dht_pkg::VAL_W){1'b0}},
                             s_tdata[KEY_W +: dht_pkg::VAL_W]};
        end
        if (PAYLOAD_BITS >= 32) begin : g_out_wide
            assign rd_pay32 = rd_pay[31:0];
        end else begin : g_out_narrow
            assign rd_pay32 = {{(32 - PAYLOAD_BITS){1'b0}}, rd_pay};
        end
    endgenerate

    // Slot store: {mark, key, payload}
    dht_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_mark = ram_rdata[PW-1 -: MARK_W];
    assign rd_key  = ram_rdata[PAYLOAD_BITS +: KEY_W];
    assign rd_pay  = ram_rdata[PAYLOAD_BITS-1:0];

    // Effective table size and step modulus
    always_comb begin
        if (tsize_reg == '0) begin
            eff_n = DW'(1);
        end else if (DW'(tsize_reg) > DW'(CAPACITY)) begin
            eff_n = DW'(CAPACITY);
        end else begin
            eff_n = DW'(tsize_reg);
        end
        eff_q = (qmod_reg == '0) ? DW'(1) : DW'(qmod_reg);
    end

    // Shared remainder step: shift in one dividend bit, subtract if it fits
    assign divisor  = (state_reg == dht_pkg::S_MODQ) ? eff_q : eff_n;
    assign trial    = {rem_reg, dvd_reg[KEY_W-1]};
    assign rem_step = (trial >= {1'b0, divisor}) ? DW'(trial - {1'b0, divisor})
                                                 : trial[DW-1:0];

    // Advance the probe slot; both terms are below n
    assign n_ext      = (SW+1)'(eff_n);
    assign slot_sum   = {1'b0, slot_reg} + {1'b0, stride_reg};
    assign slot_adv   = (slot_sum >= n_ext) ? SW'(slot_sum - n_ext) : SW'(slot_sum);
    assign last_probe = (DW'(probe_reg) + DW'(1)) == eff_n;

    assign s_tready = (state_reg == dht_pkg::S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Configuration port
    always_comb begin
        tsize_next = tsize_reg;
        qmod_next  = qmod_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                dht_pkg::REG_TABLE_SIZE: tsize_next = pwdata[CFG_W-1:0];
                dht_pkg::REG_STEP_MOD:   qmod_next  = pwdata[CFG_W-1:0];
                default:                 tsize_next = tsize_reg;
            endcase
        end
        unique case (paddr[2])
            dht_pkg::REG_TABLE_SIZE: prdata = 32'(tsize_reg);
            dht_pkg::REG_STEP_MOD:   prdata = 32'(qmod_reg);
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        dcnt_next       = dcnt_reg;
        probe_next      = probe_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        slot_next       = slot_reg;
        stride_next     = stride_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        ram_we          = 1'b0;
        ram_addr        = slot_reg;
        ram_wdata       = '0;

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            dht_pkg::S_CLEAR: begin
                // Mark every slot empty
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(CAPACITY - 1)) begin
                    state_next = dht_pkg::S_IDLE;
                end
            end
            dht_pkg::S_IDLE: begin
                if (s_xfer) begin
                    act_next  = s_tuser;
                    key_next  = s_tdata[KEY_W-1:0];
                    val_next  = pay_in;
                    dvd_next  = s_tdata[KEY_W-1:0];
                    rem_next  = '0;
                    dcnt_next = '0;
                    res_value_next = '0;
                    if (s_tuser == dht_pkg::ACT_PUT || s_tuser == dht_pkg::ACT_ERASE ||
                        s_tuser == dht_pkg::ACT_FIND) begin
                        state_next = dht_pkg::S_MODQ;
                    end else begin
                        res_status_next = dht_pkg::STAT_NOT_FOUND;
                        state_next      = dht_pkg::S_FIN;
                    end
                end
            end
            dht_pkg::S_MODQ, dht_pkg::S_MODN, dht_pkg::S_MODS: begin
                // Run the remainder unit one bit a cycle
                dvd_next  = {dvd_reg[KEY_W-2:0], 1'b0};
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + dht_pkg::DIV_CW'(1);
                if (dcnt_reg == dht_pkg::DIV_LAST) begin
                    dcnt_next = '0;
                    rem_next  = '0;
                    if (state_reg == dht_pkg::S_MODQ) begin
                        step_next  = eff_q - rem_step;
                        dvd_next   = key_reg;
                        state_next = dht_pkg::S_MODN;
                    end else if (state_reg == dht_pkg::S_MODN) begin
                        slot_next  = SW'(rem_step);
                        dvd_next   = {{(KEY_W - DW){1'b0}}, step_reg};
                        state_next = dht_pkg::S_MODS;
                    end else begin
                        stride_next = SW'(rem_step);
                        probe_next  = '0;
                        state_next  = dht_pkg::S_READ;
                    end
                end
            end
            dht_pkg::S_READ: begin
                state_next = dht_pkg::S_CHECK;
            end
            dht_pkg::S_CHECK: begin
                // Examine the slot just read
                if (act_reg == dht_pkg::ACT_PUT) begin
                    if (rd_mark != dht_pkg::MARK_OCC) begin
                        ram_we          = 1'b1;
                        ram_wdata       = {dht_pkg::MARK_OCC, key_reg, val_reg};
                        res_status_next = dht_pkg::STAT_STORED;
                        state_next      = dht_pkg::S_FIN;
                    end else if (last_probe) begin
                        res_status_next = dht_pkg::STAT_FULL;
                        state_next      = dht_pkg::S_FIN;
                    end else begin
                        slot_next  = slot_adv;
                        probe_next = probe_reg + NW'(1);
                        state_next = dht_pkg::S_READ;
                    end
                end else begin
                    if (rd_mark == dht_pkg::MARK_OCC && rd_key == key_reg) begin
                        if (act_reg == dht_pkg::ACT_ERASE) begin
                            ram_we          = 1'b1;
                            ram_wdata       = {dht_pkg::MARK_DEL, rd_key, rd_pay};
                            res_status_next = dht_pkg::STAT_ERASED;
                        end else begin
                            res_value_next  = rd_pay32;
                            res_status_next = dht_pkg::STAT_FOUND;
                        end
                        state_next = dht_pkg::S_FIN;
                    end else if (rd_mark == dht_pkg::MARK_EMPTY || last_probe) begin
                        res_status_next = (act_reg == dht_pkg::ACT_ERASE) ?
                                          dht_pkg::STAT_ERASE_MISS : dht_pkg::STAT_NOT_FOUND;
                        state_next      = dht_pkg::S_FIN;
                    end else begin
                        slot_next  = slot_adv;
                        probe_next = probe_reg + NW'(1);
                        state_next = dht_pkg::S_READ;
                    end
                end
            end
            dht_pkg::S_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    state_next    = dht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dht_pkg::S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dht_pkg::S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            tsize_reg   <= dht_pkg::TABLE_SIZE_RST;
            qmod_reg    <= dht_pkg::STEP_MOD_RST;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            tsize_reg   <= tsize_next;
            qmod_reg    <= qmod_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        dcnt_reg       <= dcnt_next;
        probe_reg      <= probe_next;
        act_reg        <= act_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        slot_reg       <= slot_next;
        stride_reg     <= stride_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_value_reg;

    // No item is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dht_pkg::S_CLEAR |-> !s_tready)
        else $error("item accepted during clearing pass");

    // Slot RAM is written only while clearing or deciding a probe
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == dht_pkg::S_CLEAR || state_reg == dht_pkg::S_CHECK))
        else $error("slot write outside clear or check");

    // Probe count and slot stay inside the table
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dht_pkg::S_CHECK |-> (DW'(probe_reg) < eff_n && DW'(slot_reg) < eff_n))
        else $error("probe beyond table size");

    // A value is shown only with a hit
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != dht_pkg::STAT_FOUND) |-> m_tdata == '0)
        else $error("nonzero value without a hit");

    // A new result lands only after the previous one has been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_status_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: test/tb_double_hash_table.sv
// Self-checking testbench for the double-hashing table: directed plan, then randomised traffic.
`timescale 1ns / 1ps

module tb_double_hash_table;

    localparam int          KEY_W      = dht_pkg::KEY_W;
    localparam int          VAL_W      = dht_pkg::VAL_W;
    localparam int          ACT_W      = dht_pkg::ACT_W;
    localparam int          STAT_W     = dht_pkg::STAT_W;
    localparam int          CFG_W      = dht_pkg::CFG_W;
    localparam int          MARK_W     = dht_pkg::MARK_W;
    localparam int          CAPACITY   = 1024;
    localparam int          LIMIT      = 3_000_000;
    localparam int          SEGMENTS   = 9;
    localparam int          POOL_KEYS  = 8;
    localparam logic [2:0]  ADDR_TABLE_SIZE = 3'd0;
    localparam logic [2:0]  ADDR_STEP_MOD   = 3'd4;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic        ROW_OP     = 1'b0;
    localparam logic        ROW_CFG    = 1'b1;
    localparam logic        TYPED      = 1'b1;
    localparam logic        PREDICTED  = 1'b0;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
    } result_t;

    // One line of the directed plan; a configuration row carries size in key, step in val
    typedef struct packed {
        logic              is_cfg;
        logic [ACT_W-1:0]  act;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
        logic              typed;
        logic [STAT_W-1:0] st;
        logic [VAL_W-1:0]  fv;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the table contents and registers
    logic [MARK_W-1:0] slot_mark_sh [CAPACITY];
    logic [KEY_W-1:0]  slot_key_sh  [CAPACITY];
    logic [VAL_W-1:0]  slot_word_sh [CAPACITY];
    logic [CFG_W-1:0]  tbl_size = dht_pkg::TABLE_SIZE_RST;
    logic [CFG_W-1:0]  step_mod = dht_pkg::STEP_MOD_RST;

    result_t awaited_results [$];
    row_t    plan [$];
    int      status_seen [6];
    int      errors   = 0;
    int      sent     = 0;
    int      settings = 0;
    int      cycles   = 0;
    int      idle_pct  = 0;
    int      stall_pct = 0;

    double_hash_table #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Give up on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_double_hash_table NOT OK");
            $finish;
        end
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Walk the probe sequence for one operation and update the shadow table
    function automatic result_t table_op_outcome(input logic [ACT_W-1:0] act,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [VAL_W-1:0] val);
        result_t     r;
        int unsigned n, q, stride, slot, i;
        n = (tbl_size == 0) ? 1 : (tbl_size > CAPACITY) ? CAPACITY : tbl_size;
        q = (step_mod == 0) ? 1 : step_mod;
        stride = q - (key % q);
        slot = key % n;
        r.status = dht_pkg::STAT_NOT_FOUND;
        r.value = '0;
        if (act == dht_pkg::ACT_PUT) begin
            r.status = dht_pkg::STAT_FULL;
            for (i = 0; i < n; i++) begin
                if (slot_mark_sh[slot] != dht_pkg::MARK_OCC) begin
                    slot_mark_sh[slot] = dht_pkg::MARK_OCC;
                    slot_key_sh[slot] = key;
                    slot_word_sh[slot] = val;
                    r.status = dht_pkg::STAT_STORED;
                    break;
                end
                slot = (slot + stride) % n;
            end
        end else if (act == dht_pkg::ACT_ERASE || act == dht_pkg::ACT_FIND) begin
            r.status = (act == dht_pkg::ACT_ERASE) ? dht_pkg::STAT_ERASE_MISS
                                                   : dht_pkg::STAT_NOT_FOUND;
            for (i = 0; i < n; i++) begin
                if (slot_mark_sh[slot] == dht_pkg::MARK_EMPTY)
                    break;
                if (slot_mark_sh[slot] == dht_pkg::MARK_OCC && slot_key_sh[slot] == key) begin
                    if (act == dht_pkg::ACT_ERASE) begin
                        slot_mark_sh[slot] = dht_pkg::MARK_DEL;
                        r.status = dht_pkg::STAT_ERASED;
                    end else begin
                        r.value = slot_word_sh[slot];
                        r.status = dht_pkg::STAT_FOUND;
                    end
                    break;
                end
                slot = (slot + stride) % n;
            end
        end
        return r;
    endfunction

    // Compare each result transfer with the oldest outstanding expectation
    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d, found_value %h", m_tuser, m_tdata);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.value) begin
                    $error("found_value: expected %h, actual %h", want.value, m_tdata);
                    errors++;
                end
                if (want.status <= dht_pkg::STAT_NOT_FOUND)
                    status_seen[want.status]++;
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want, input string name);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for outstanding results, then write both registers and read them back
    task automatic set_config(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] q);
        logic [31:0] junk;
        while (awaited_results.size() != 0) @(posedge aclk);
        junk = $urandom();
        apb_write(ADDR_TABLE_SIZE, {junk[31:CFG_W], n});
        junk = $urandom();
        apb_write(ADDR_STEP_MOD, {junk[31:CFG_W], q});
        tbl_size = n;
        step_mod = q;
        apb_check(ADDR_TABLE_SIZE, {21'b0, n}, "table_size");
        apb_check(ADDR_STEP_MOD, {21'b0, q}, "step_modulus");
        settings++;
    endtask

    // Offer one operation transfer, then record what it should produce
    task automatic push_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input result_t typed_res);
        result_t r;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, val, key};
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        r = table_op_outcome(act, key, val);
        awaited_results.push_back(typed ? typed_res : r);
        sent++;
    endtask

    task automatic plan_row(input logic is_cfg, input logic [ACT_W-1:0] act,
                            input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
                            input logic typed, input logic [STAT_W-1:0] st,
                            input logic [VAL_W-1:0] fv);
        plan.push_back({is_cfg, act, key, val, typed, st, fv});
    endtask

    // Pacing phases: none, sender idle, receiver stalled, both lightly
    task automatic set_pacing(input int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 7; stall_pct = 7; end
        endcase
    endtask

    initial begin
        logic [KEY_W-1:0] pool [POOL_KEYS];
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [ACT_W-1:0] act;
        logic [CFG_W-1:0] n, q;
        int               count, neff, pick, seg, i;

        foreach (slot_mark_sh[s])
            slot_mark_sh[s] = dht_pkg::MARK_EMPTY;
        foreach (status_seen[s])
            status_seen[s] = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers come up at their reset values
        apb_check(ADDR_TABLE_SIZE, {21'b0, dht_pkg::TABLE_SIZE_RST}, "table_size");
        apb_check(ADDR_STEP_MOD, {21'b0, dht_pkg::STEP_MOD_RST}, "step_modulus");

        // Empty table, extremes, collisions and reuse of a deleted slot
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd0, 32'd0,
                 TYPED, dht_pkg::STAT_NOT_FOUND, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_ERASE, 31'h7FFFFFFF, 32'd0,
                 TYPED, dht_pkg::STAT_ERASE_MISS, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'd0, 32'd0,
                 TYPED, dht_pkg::STAT_STORED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'h7FFFFFFF, 32'hFFFFFFFF,
                 TYPED, dht_pkg::STAT_STORED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'h7FFFFFFF, 32'd0,
                 TYPED, dht_pkg::STAT_FOUND, 32'hFFFFFFFF);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd0, 32'd0,
                 TYPED, dht_pkg::STAT_FOUND, 32'd0);
        plan_row(ROW_OP, ACT_UNUSED, 31'd0, 32'hFFFFFFFF,
                 TYPED, dht_pkg::STAT_NOT_FOUND, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'd1024, 32'hA5A5A5A5,
                 TYPED, dht_pkg::STAT_STORED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd1024, 32'd0,
                 TYPED, dht_pkg::STAT_FOUND, 32'hA5A5A5A5);
        plan_row(ROW_OP, dht_pkg::ACT_ERASE, 31'd0, 32'd0,
                 TYPED, dht_pkg::STAT_ERASED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd1024, 32'd0,
                 TYPED, dht_pkg::STAT_FOUND, 32'hA5A5A5A5);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd0, 32'd0,
                 TYPED, dht_pkg::STAT_NOT_FOUND, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'd2048, 32'h12345678,
                 TYPED, dht_pkg::STAT_STORED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_ERASE, 31'd0, 32'd0,
                 TYPED, dht_pkg::STAT_ERASE_MISS, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'h2AAAAAAA, 32'h5555AAAA, PREDICTED, '0, '0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'h2AAAAAAA, 32'd0, PREDICTED, '0, '0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'h55555555, 32'd0, PREDICTED, '0, '0);
        // Zero size and zero step behave as one; slots beyond the size are kept
        plan_row(ROW_CFG, dht_pkg::ACT_PUT, 31'd0, 32'd0, PREDICTED, '0, '0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'd5, 32'h77,
                 TYPED, dht_pkg::STAT_FULL, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd2048, 32'd0,
                 TYPED, dht_pkg::STAT_FOUND, 32'h12345678);
        plan_row(ROW_OP, dht_pkg::ACT_ERASE, 31'd2048, 32'd0,
                 TYPED, dht_pkg::STAT_ERASED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'd5, 32'h77,
                 TYPED, dht_pkg::STAT_STORED, 32'd0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd5, 32'd0,
                 TYPED, dht_pkg::STAT_FOUND, 32'h77);
        // Oversized table saturates to capacity; widest step modulus
        plan_row(ROW_CFG, dht_pkg::ACT_PUT, 31'd2047, 32'd2047, PREDICTED, '0, '0);
        plan_row(ROW_OP, dht_pkg::ACT_FIND, 31'd1024, 32'd0, PREDICTED, '0, '0);
        plan_row(ROW_OP, dht_pkg::ACT_PUT, 31'h7FFFFFFF, 32'd0, PREDICTED, '0, '0);
        plan_row(ROW_OP, dht_pkg::ACT_ERASE, 31'h7FFFFFFF, 32'd0, PREDICTED, '0, '0);

        set_pacing(0);
        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                s_tvalid <= 1'b0;
                set_config(plan[r].key[CFG_W-1:0], plan[r].val[CFG_W-1:0]);
            end else begin
                push_op(plan[r].act, plan[r].key, plan[r].val, plan[r].typed,
                        result_t'({plan[r].st, plan[r].fv}));
            end
        end
        s_tvalid <= 1'b0;

        // Random traffic over a small key pool per table setting, so keys collide and recur
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin n = 11'd1;    q = 11'd1;    count = 180; end
                1: begin n = 11'd0;    q = 11'd0;    count = 160; end
                2: begin n = 11'd7;    q = 11'd5;    count = 240; end
                3: begin n = 11'd13;   q = 11'd11;   count = 240; end
                4: begin n = 11'd16;   q = 11'd6;    count = 220; end
                5: begin n = 11'd2047; q = 11'd1024; count = 120; end
                6: begin n = 11'd31;   q = 11'd2047; count = 240; end
                7: begin
                    n = CFG_W'($urandom_range(2, 64));
                    q = CFG_W'($urandom_range(1, 64));
                    count = 240;
                end
                default: begin n = 11'd1024; q = 11'd1; count = 210; end
            endcase
            set_config(n, q);
            neff = (n == 0) ? 1 : (n > CAPACITY) ? CAPACITY : n;
            foreach (pool[k])
                pool[k] = KEY_W'($urandom_range(0, 3 * neff + 8));

            for (i = 0; i < count; i++) begin
                if (i % 50 == 0)
                    set_pacing(seg + i / 50);
                pick = $urandom_range(0, 99);
                act = (pick < 40) ? dht_pkg::ACT_PUT : (pick < 62) ? dht_pkg::ACT_ERASE :
                      (pick < 95) ? dht_pkg::ACT_FIND : ACT_UNUSED;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    key = pool[$urandom_range(0, POOL_KEYS - 1)];
                else if (pick < 83)
                    key = 31'h7FFFFFFF;
                else if (pick < 86)
                    key = '0;
                else
                    key = KEY_W'($urandom());
                pick = $urandom_range(0, 99);
                val = (pick < 5) ? 32'd0 : (pick < 10) ? 32'hFFFFFFFF : $urandom();
                push_op(act, key, val, PREDICTED, '0);
            end
            s_tvalid <= 1'b0;
        end

        // Let the last results arrive, then watch for strays
        set_pacing(0);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Ran %0d operations over %0d register settings with all pacing phases.",
                 sent, settings);
        $display("Results: stored %0d, full %0d, erased %0d, erase missed %0d, %s %0d, %s %0d",
                 status_seen[dht_pkg::STAT_STORED], status_seen[dht_pkg::STAT_FULL],
                 status_seen[dht_pkg::STAT_ERASED], status_seen[dht_pkg::STAT_ERASE_MISS],
                 "found", status_seen[dht_pkg::STAT_FOUND],
                 "missing", status_seen[dht_pkg::STAT_NOT_FOUND]);
        if (errors == 0)
            $display("tb_double_hash_table OK");
        else
            $display("tb_double_hash_table NOT OK");
        $finish;
    end

endmodule
